// ----- rtl/core/kstoa_pkg.sv -----
package kstoa_pkg;

  localparam int unsigned SeqMax = 4;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] MAP_ROWS   = 7'h55;

  localparam logic [7:0] EXT_UP     = 8'h48;
  localparam logic [7:0] EXT_LEFT   = 8'h4B;
  localparam logic [7:0] EXT_RIGHT  = 8'h4D;
  localparam logic [7:0] EXT_DOWN   = 8'h50;
  localparam logic [7:0] EXT_HOME   = 8'h47;
  localparam logic [7:0] EXT_END    = 8'h4F;
  localparam logic [7:0] EXT_DEL    = 8'h53;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_LOWER_C = 8'h63;

  // Result sequence for one scancode; chars[0] goes out first.
  typedef struct packed {
    logic [SeqMax-1:0][7:0] chars;
    logic [2:0]             cnt;
    logic                   irq;
  } kstoa_seq_t;

  // Keymap ROM: returns {shifted, plain}.
  function automatic logic [15:0] keymap(input logic [6:0] code);
    logic [15:0] row;
    case (code)
      7'h01: row = 16'h0101;
      7'h02: row = 16'h2131;
      7'h03: row = 16'h4032;
      7'h04: row = 16'h2333;
      7'h05: row = 16'h2434;
      7'h06: row = 16'h2535;
      7'h07: row = 16'h5E36;
      7'h08: row = 16'h2637;
      7'h09: row = 16'h2A38;
      7'h0A: row = 16'h2839;
      7'h0B: row = 16'h2930;
      7'h0C: row = 16'h5F2D;
      7'h0D: row = 16'h2B3D;
      7'h0E: row = 16'h7F7F;
      7'h0F: row = 16'h0909;
      7'h10: row = 16'h5171;
      7'h11: row = 16'h5777;
      7'h12: row = 16'h4565;
      7'h13: row = 16'h5272;
      7'h14: row = 16'h5474;
      7'h15: row = 16'h5979;
      7'h16: row = 16'h5575;
      7'h17: row = 16'h4969;
      7'h18: row = 16'h4F6F;
      7'h19: row = 16'h5070;
      7'h1A: row = 16'h7B5B;
      7'h1B: row = 16'h7D5D;
      7'h1C: row = 16'h0A0A;
      7'h1E: row = 16'h4161;
      7'h1F: row = 16'h5373;
      7'h20: row = 16'h4464;
      7'h21: row = 16'h4666;
      7'h22: row = 16'h4767;
      7'h23: row = 16'h4868;
      7'h24: row = 16'h4A6A;
      7'h25: row = 16'h4B6B;
      7'h26: row = 16'h4C6C;
      7'h27: row = 16'h3A3B;
      7'h28: row = 16'h2227;
      7'h29: row = 16'h7E60;
      7'h2B: row = 16'h7C5C;
      7'h2C: row = 16'h5A7A;
      7'h2D: row = 16'h5878;
      7'h2E: row = 16'h4363;
      7'h2F: row = 16'h5676;
      7'h30: row = 16'h4262;
      7'h31: row = 16'h4E6E;
      7'h32: row = 16'h4D6D;
      7'h33: row = 16'h3C2C;
      7'h34: row = 16'h3E2E;
      7'h35: row = 16'h3F2F;
      7'h37: row = 16'h2A2A;
      7'h39: row = 16'h2020;
      7'h47: row = 16'h3737;
      7'h48: row = 16'h0303;
      7'h49: row = 16'h3939;
      7'h4A: row = 16'h2D2D;
      7'h4B: row = 16'h3434;
      7'h4C: row = 16'h3535;
      7'h4D: row = 16'h3636;
      7'h4E: row = 16'h2B2B;
      7'h4F: row = 16'h3131;
      7'h50: row = 16'h0505;
      7'h51: row = 16'h3333;
      7'h52: row = 16'h3030;
      7'h53: row = 16'h2E2E;
      default: row = 16'h0000;
    endcase
    return row;
  endfunction

endpackage

// ----- rtl/core/keyboard_scancode_to_ascii.sv -----
// Channel   | Dir | Ports                    | Carries
// ----------+-----+--------------------------+-----------------------------------
// in_       | in  | tvalid tready tdata      | one scancode byte per request
// out_      | out | tvalid tready tdata      | one result byte per request
//           |     | tuser tlast              | tuser = interrupt request, tlast =
//           |     |                          | final result of the scancode
//
// A scancode is registered on accept, decoded once the sequence register is free
// and its result bytes (none, one, three or four) are loaded into a sequence
// register that sends one byte per cycle while the output is not stalled.
// Reset clears the key bits, the prefix flag and both valid registers.
// A stalled output holds the sequence; a new scancode waits in the input
// register and is still accepted while the last byte of a sequence leaves.
module keyboard_scancode_to_ascii import kstoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scan_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic       out_tuser,  // [0] interrupt_request
  output logic       out_tlast
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;

  logic [SeqMax-1:0][7:0] chars_r, chars_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic                   irq_r, irq_nxt;

  logic       seq_free;
  logic       decode_fire;
  logic       out_fire;
  kstoa_seq_t dec_seq;

  // The sequence register is free when empty or when its last byte leaves now.
  assign out_fire    = out_tvalid & out_tready;
  assign seq_free    = (cnt_r == 3'd0) | ((cnt_r == 3'd1) & out_tready);
  assign decode_fire = in_valid_r & seq_free;
  assign in_tready   = ~in_valid_r | seq_free;

  kstoa_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (decode_fire),
    .scan_byte (in_byte_r),
    .seq       (dec_seq)
  );

  // Input register: hold the request until the decoder can take it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Sequence register: load on decode, advance one byte per output request.
  always_comb begin
    chars_nxt = chars_r;
    cnt_nxt   = cnt_r;
    irq_nxt   = irq_r;
    if (decode_fire) begin
      chars_nxt = dec_seq.chars;
      cnt_nxt   = dec_seq.cnt;
      irq_nxt   = dec_seq.irq;
    end else if (out_fire) begin
      chars_nxt = {8'h00, chars_r[SeqMax-1:1]};
      cnt_nxt   = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    irq_r   <= irq_nxt;
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = chars_r[0];
  assign out_tuser  = irq_r;
  assign out_tlast  = (cnt_r == 3'd1);

endmodule

// ----- rtl/core/kstoa_decode.sv -----
// Scancode decoder: modifier and prefix state, keymap lookup, escape sequences.
module kstoa_decode import kstoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] scan_byte,
  output kstoa_seq_t seq
);

  // Only the modifier keys are ever read back, so only their bits are kept.
  logic ext_r, ext_nxt;
  logic lshift_r, rshift_r, ctrl_r, alt_r, caps_r;
  logic lshift_nxt, rshift_nxt, ctrl_nxt, alt_nxt, caps_nxt;

  logic        press;
  logic [6:0]  code;
  logic        shift;
  logic        col;
  logic [15:0] row;
  logic [7:0]  ch;

  always_comb begin
    press      = ~scan_byte[7];
    code       = scan_byte[6:0];
    ext_nxt    = ext_r;
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    caps_nxt   = caps_r;
    seq        = '0;
    shift      = 1'b0;
    col        = 1'b0;
    row        = '0;
    ch         = '0;

    if (ext_r) begin
      ext_nxt       = 1'b0;
      seq.chars[0]  = CH_ESC;
      seq.chars[1]  = CH_BRACKET;
      seq.cnt       = 3'd3;
      case (scan_byte)
        EXT_UP:    seq.chars[2] = 8'h41;
        EXT_LEFT:  seq.chars[2] = 8'h44;
        EXT_RIGHT: seq.chars[2] = 8'h43;
        EXT_DOWN:  seq.chars[2] = 8'h42;
        EXT_HOME:  seq.chars[2] = 8'h48;
        EXT_END:   seq.chars[2] = 8'h46;
        EXT_DEL: begin
          seq.chars[2] = 8'h33;
          seq.chars[3] = 8'h7E;
          seq.cnt      = 3'd4;
        end
        default: seq = '0;
      endcase
    end else if (scan_byte == PREFIX_EXT) begin
      ext_nxt = 1'b1;
    end else begin
      if (code == KEY_LSHIFT) lshift_nxt = press;
      if (code == KEY_RSHIFT) rshift_nxt = press;
      if (code == KEY_CTRL)   ctrl_nxt   = press;
      if (code == KEY_ALT)    alt_nxt    = press;
      if (code == KEY_CAPS)   caps_nxt   = press;
      // Look up with the key bits as they stand after this code.
      shift = lshift_nxt | rshift_nxt;
      col   = shift ^ caps_nxt;
      row   = keymap(code);
      ch    = col ? row[15:8] : row[7:0];
      if (press && (code < MAP_ROWS) && (ch != 8'h00)) begin
        seq.cnt = 3'd1;
        if (ch == CH_LOWER_C && ctrl_nxt && !shift && !alt_nxt) begin
          seq.irq = 1'b1;
        end else begin
          seq.chars[0] = ch;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r    <= 1'b0;
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      ctrl_r   <= 1'b0;
      alt_r    <= 1'b0;
      caps_r   <= 1'b0;
    end else if (fire) begin
      ext_r    <= ext_nxt;
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      ctrl_r   <= ctrl_nxt;
      alt_r    <= alt_nxt;
      caps_r   <= caps_nxt;
    end
  end

endmodule

// ----- rtl/core/kstoa_checker.sv -----
module kstoa_checker import kstoa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // An interrupt request carries no character and ends its scancode.
  a_irq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h00 && out_tlast)
    else $error("interrupt request with character or without last");

  // Hold the result while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("output changed while stalled");

  // ESC of an escape sequence is followed at once by a bracket.
  a_esc_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == CH_ESC && !out_tlast
      |=> out_tvalid && out_tdata == CH_BRACKET && !out_tlast)
    else $error("escape not followed by bracket");

  // A bracket inside a sequence is followed by a cursor or delete code.
  a_bracket_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == CH_BRACKET && !out_tlast
      |=> out_tvalid && (out_tdata == 8'h41 || out_tdata == 8'h42 ||
        out_tdata == 8'h43 || out_tdata == 8'h44 || out_tdata == 8'h48 ||
        out_tdata == 8'h46 || out_tdata == 8'h33))
    else $error("bad code after bracket");

  // Input backpressure only while results are pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind keyboard_scancode_to_ascii kstoa_checker u_kstoa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
